// ===== rtl/cos_pkg.sv =====
package cos_pkg;

  localparam int CoordWidth = 48;
  localparam int AngWidth   = 34;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AngWidth-1:0]   ang_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    ang_t   a;
  } lane_t;

  typedef struct packed {
    logic        op;
    logic        zero;
    logic [31:0] z;
  } meta_t;

  typedef enum logic [1:0] {
    REG_OFFSET_RADIUS = 2'd0,
    REG_OFFSET_ANGLE  = 2'd1,
    REG_OFFSET_Z      = 2'd2
  } reg_index_t;

  localparam logic OP_ADD = 1'b0;

  localparam ang_t ANG_QUARTER = 34'sh040000000;
  localparam ang_t ANG_HALF    = 34'sh080000000;

  localparam logic [30:0] INV_GAIN_SQ = 31'd1583795506;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // radius on x axis, angle folded into +-pi/2
  function automatic lane_t polar_init(logic [31:0] r, logic signed [15:0] ang);
    lane_t l;
    ang_t  a;
    coord_t x;
    a = {{2{ang[15]}}, ang, 16'b0};
    x = {8'b0, r, 8'b0};
    if (a > ANG_QUARTER) begin
      a = a - ANG_HALF;
      x = -x;
    end else if (a < -ANG_QUARTER) begin
      a = a + ANG_HALF;
      x = -x;
    end
    l.x = x;
    l.y = '0;
    l.a = a;
    return l;
  endfunction

endpackage

// ===== rtl/cos_cordic_stage.sv =====
module cos_cordic_stage #(
  parameter int SHIFT     = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cos_pkg::lane_t in_lane,
  input  cos_pkg::meta_t in_meta,
  output logic           out_valid,
  output cos_pkg::lane_t out_lane,
  output cos_pkg::meta_t out_meta
);
  import cos_pkg::*;

  localparam ang_t STEP = ang_t'(ATAN_TAB[SHIFT]);

  coord_t dx;
  coord_t dy;
  logic   neg;
  lane_t  lane_next;

  assign dx  = in_lane.y >>> SHIFT;
  assign dy  = in_lane.x >>> SHIFT;
  // rotation drives the angle to zero, vectoring drives y to zero
  assign neg = VECTORING ? in_lane.y[CoordWidth-1] : !in_lane.a[AngWidth-1];

  always_comb begin
    if (neg) begin
      lane_next.x = in_lane.x - dx;
      lane_next.y = in_lane.y + dy;
      lane_next.a = in_lane.a - STEP;
    end else begin
      lane_next.x = in_lane.x + dx;
      lane_next.y = in_lane.y - dy;
      lane_next.a = in_lane.a + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
      out_meta <= in_meta;
    end
  end

endmodule

// ===== rtl/cos_gain.sv =====
module cos_gain (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cos_pkg::lane_t in_lane,
  input  cos_pkg::meta_t in_meta,
  output logic           out_valid,
  output logic [31:0]    out_radius,
  output logic [15:0]    out_angle,
  output logic [31:0]    out_z,
  output logic           overflow
);
  import cos_pkg::*;

  logic [46:0] mag;
  logic [26:0] hi;
  logic [19:0] lo;
  ang_t        ang_rnd;

  logic        v1;
  logic [57:0] ph;
  logic [50:0] pl;
  logic [15:0] ang1;
  logic [31:0] z1;
  logic        zero1;

  logic [58:0] t;
  logic [39:0] t_rnd;

  assign mag     = in_lane.x[CoordWidth-1] ? '0 : in_lane.x[46:0];
  assign hi      = mag[46:20];
  assign lo      = mag[19:0];
  assign ang_rnd = in_lane.a + ang_t'(34'h8000);

  assign t     = {1'b0, ph} + 59'(pl >> 20);
  assign t_rnd = 40'((t + 59'(1 << 19)) >> 20);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph    <= hi * INV_GAIN_SQ;
      pl    <= lo * INV_GAIN_SQ;
      ang1  <= ang_rnd[31:16];
      z1    <= in_meta.z;
      zero1 <= in_meta.zero;
      out_z <= z1;
      if (zero1) begin
        out_radius <= '0;
        out_angle  <= '0;
        overflow   <= 1'b0;
      end else begin
        out_angle <= ang1;
        if (|t_rnd[39:32]) begin
          out_radius <= '1;
          overflow   <= 1'b1;
        end else begin
          out_radius <= t_rnd[31:0];
          overflow   <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> out_radius == 32'hFFFFFFFF)
    else $error("overflow without saturated radius");
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid && !v1)
    else $error("valid survived reset");
  // vectoring never lets x go below zero once the left half plane is folded
  a_mag_pos: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_meta.zero |-> !in_lane.x[CoordWidth-1])
    else $error("vectoring magnitude check");
`endif

endmodule

// ===== rtl/cylindrical_origin_shift.sv =====
// cylindrical origin shift: moves a cylindrical point (radius, angle, z) into a
// frame whose origin sits at a configured polar offset. opcode 0 adds the
// offset, opcode 1 subtracts it.
// input channel: in_valid / in_stall with opcode, in_radius, in_angle, in_z.
// output channel: out_valid / out_stall with out_radius, out_angle, out_z,
// overflow (radius saturated to all ones).
// config: cfg_we, cfg_index (0 radius, 1 angle, 2 z), cfg_data; write only
// while the block is empty.
// throughput: one item per cycle while the receiver is not stalling. the path
// holds one register per cordic iteration in the rotation and vectoring pipes
// plus entry, combine and a two-step gain multiply.
// reset clears all valid bits and the offset registers; a stall from the
// receiver freezes the whole pipe and holds the output register, and
// in_stall follows out_valid && out_stall.
module cylindrical_origin_shift #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] in_radius,
  input  logic [15:0] in_angle,
  input  logic [31:0] in_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_radius,
  output logic [15:0] out_angle,
  output logic [31:0] out_z,
  output logic        overflow,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cos_pkg::*;

  logic [31:0]        offset_radius;
  logic signed [15:0] offset_angle;
  logic [31:0]        offset_z;

  logic adv;

  lane_t rp [CORDIC_STAGES+1];
  lane_t ro [CORDIC_STAGES+1];
  meta_t rm [CORDIC_STAGES+1];
  logic  rv [CORDIC_STAGES+1];

  lane_t vl [CORDIC_STAGES+1];
  meta_t vm [CORDIC_STAGES+1];
  logic  vv [CORDIC_STAGES+1];

  lane_t comb_lane;
  meta_t comb_meta;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_radius <= '0;
      offset_angle  <= '0;
      offset_z      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_RADIUS: offset_radius <= cfg_data;
        REG_OFFSET_ANGLE:  offset_angle  <= cfg_data[15:0];
        REG_OFFSET_Z:      offset_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp[0]      <= polar_init(in_radius, in_angle);
      ro[0]      <= polar_init(offset_radius, offset_angle);
      rm[0].op   <= opcode;
      rm[0].zero <= 1'b0;
      rm[0].z    <= (opcode == OP_ADD) ? in_z + offset_z : in_z - offset_z;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    cos_cordic_stage #(.SHIFT(k), .VECTORING(1'b0)) u_pt (
      .clk, .rst, .en(adv),
      .in_valid(rv[k]), .in_lane(rp[k]), .in_meta(rm[k]),
      .out_valid(rv[k+1]), .out_lane(rp[k+1]), .out_meta(rm[k+1])
    );
    cos_cordic_stage #(.SHIFT(k), .VECTORING(1'b0)) u_off (
      .clk, .rst, .en(adv),
      .in_valid(1'b0), .in_lane(ro[k]), .in_meta(rm[k]),
      .out_valid(), .out_lane(ro[k+1]), .out_meta()
    );
  end

  // combine point and offset, fold left half plane by pi
  always_comb begin
    comb_meta = rm[CORDIC_STAGES];
    if (comb_meta.op == OP_ADD) begin
      comb_lane.x = rp[CORDIC_STAGES].x + ro[CORDIC_STAGES].x;
      comb_lane.y = rp[CORDIC_STAGES].y + ro[CORDIC_STAGES].y;
    end else begin
      comb_lane.x = rp[CORDIC_STAGES].x - ro[CORDIC_STAGES].x;
      comb_lane.y = rp[CORDIC_STAGES].y - ro[CORDIC_STAGES].y;
    end
    comb_meta.zero = (comb_lane.x == '0) && (comb_lane.y == '0);
    comb_lane.a = '0;
    if (comb_lane.x[CoordWidth-1]) begin
      comb_lane.x = -comb_lane.x;
      comb_lane.y = -comb_lane.y;
      comb_lane.a = ANG_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= rv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vl[0] <= comb_lane;
      vm[0] <= comb_meta;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    cos_cordic_stage #(.SHIFT(k), .VECTORING(1'b1)) u_vec (
      .clk, .rst, .en(adv),
      .in_valid(vv[k]), .in_lane(vl[k]), .in_meta(vm[k]),
      .out_valid(vv[k+1]), .out_lane(vl[k+1]), .out_meta(vm[k+1])
    );
  end

  cos_gain u_gain (
    .clk, .rst, .en(adv),
    .in_valid(vv[CORDIC_STAGES]), .in_lane(vl[CORDIC_STAGES]),
    .in_meta(vm[CORDIC_STAGES]),
    .out_valid, .out_radius, .out_angle, .out_z, .overflow
  );

`ifndef SYNTHESIS
  a_fold: assert property (@(posedge clk) disable iff (rst)
    vv[0] |-> !vl[0].x[CoordWidth-1])
    else $error("combine stage left x negative");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    vv[0] && vm[0].zero |-> vl[0].x == '0 && vl[0].y == '0)
    else $error("zero flag on nonzero vector");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rv[0]))
    else $error("pipe moved under stall");
`endif

endmodule
